[rtl/sem_pkg.sv]
// Shared constants for the 3x3 Sobel edge magnitude block.
package sem_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_W      = 13;
  localparam int IDX_W      = 2;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 10;
  localparam int SQ_IN_W    = 2 * GRAD_W + 1;
  localparam int SQ_OUT_W   = GRAD_W + 1;
  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);
  localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(255);
endpackage

[rtl/sobel_edge_magnitude_3x3.sv]
// Top level: streaming 3x3 Sobel edge magnitude with two line memories.
// One request at a time: an interior result passes memory read, gradient, squares,
// 11-step square root unit and result, then a border result too if the pixel has one.
// A border-only pixel goes from memory read to its result; a pixel with no result goes
// back to idle after the read. Output stalls hold the result states. Sync reset clears
// control, counters, window and registers to 640 x 480; line memories are not cleared.
module sobel_edge_magnitude_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [sem_pkg::IDX_W-1:0]     wr_index,
  input  logic [sem_pkg::CFG_W-1:0]     wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sem_pkg::PIX_W-1:0]     pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sem_pkg::PIX_W-1:0]     pixel_out,
  output logic [sem_pkg::ROW_W-1:0]     out_row,
  output logic [sem_pkg::COL_W-1:0]     out_col,
  output logic                          last_of_run,
  output logic                          end_of_frame
);
  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SQ, S_SUM, S_ROOT, S_EMIT_A, S_EMIT_B
  } state_t;

  state_t state;

  logic [sem_pkg::FW_W-1:0]  frame_width;
  logic [sem_pkg::FH_W-1:0]  frame_height;
  logic [sem_pkg::FW_W-1:0]  w_eff;
  logic [sem_pkg::FH_W-1:0]  h_eff;
  logic [sem_pkg::COL_W-1:0] col_count;
  logic [sem_pkg::ROW_W-1:0] row_count;
  logic [sem_pkg::COL_W-1:0] c_eff;
  logic [sem_pkg::ROW_W-1:0] r_eff;
  logic                      accept;
  logic                      is_int, is_bord, is_eof;

  logic [sem_pkg::COL_W-1:0] c_q;
  logic [sem_pkg::ROW_W-1:0] r_q;
  logic [sem_pkg::PIX_W-1:0] px_q;
  logic                      int_q, bord_q, eof_q;

  logic [sem_pkg::PIX_W-1:0] upper [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] middle [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] top_q, mid_q;
  logic [sem_pkg::PIX_W-1:0] win [6];

  logic [sem_pkg::GRAD_W-1:0] gx_r, gx_l, gy_b, gy_t, a_next, b_next;
  logic [sem_pkg::GRAD_W-1:0] a_q, b_q;
  logic [2*sem_pkg::GRAD_W-1:0] sq_a;
  logic [sem_pkg::SQ_IN_W-1:0]  sq_sum;
  logic                         sq_done;
  logic [sem_pkg::SQ_OUT_W-1:0] sq_root;
  logic [sem_pkg::PIX_W-1:0]    mag_q;
  logic [sem_pkg::SQ_OUT_W-3:0] quarter;
  logic                         slot_free;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = sem_pkg::FW_W'(1);
    end else if (frame_width > sem_pkg::FW_W'(sem_pkg::MAX_WIDTH)) begin
      w_eff = sem_pkg::FW_W'(sem_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = sem_pkg::FH_W'(1);
    end else if (frame_height > sem_pkg::FH_W'(sem_pkg::MAX_HEIGHT)) begin
      h_eff = sem_pkg::FH_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign c_eff   = ({1'b0, col_count} >= w_eff) ? '0 : col_count;
  assign r_eff   = ({1'b0, row_count} >= h_eff) ? '0 : row_count;
  assign is_int  = (r_eff >= sem_pkg::ROW_W'(2)) && (c_eff >= sem_pkg::COL_W'(2));
  assign is_eof  = ({1'b0, r_eff} == h_eff - 1'b1) && ({1'b0, c_eff} == w_eff - 1'b1);
  assign is_bord = (r_eff == '0) || (c_eff == '0) || ({1'b0, r_eff} == h_eff - 1'b1)
                   || ({1'b0, c_eff} == w_eff - 1'b1);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // gradient terms: left column win[0..2], middle win[3..5], right top_q/mid_q/px_q
  assign gx_r = {2'b0, top_q} + {1'b0, mid_q, 1'b0} + {2'b0, px_q};
  assign gx_l = {2'b0, win[0]} + {1'b0, win[1], 1'b0} + {2'b0, win[2]};
  assign gy_b = {2'b0, win[2]} + {1'b0, win[5], 1'b0} + {2'b0, px_q};
  assign gy_t = {2'b0, win[0]} + {1'b0, win[3], 1'b0} + {2'b0, top_q};
  assign a_next = (gx_r >= gx_l) ? gx_r - gx_l : gx_l - gx_r;
  assign b_next = (gy_b >= gy_t) ? gy_b - gy_t : gy_t - gy_b;
  assign sq_sum = {1'b0, sq_a} + SQ_IN_W_CAST(b_q);
  assign quarter = sq_root[sem_pkg::SQ_OUT_W-1:2];

  function automatic logic [sem_pkg::SQ_IN_W-1:0] SQ_IN_W_CAST(
      input logic [sem_pkg::GRAD_W-1:0] x);
    logic [2*sem_pkg::GRAD_W-1:0] p;
    p = x * x;
    return {1'b0, p};
  endfunction

  always_ff @(posedge clk) begin
    if (accept) begin
      top_q <= upper[c_eff];
    end
    if (state == S_RD) begin
      upper[c_q] <= mid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_q <= middle[c_eff];
    end
    if (state == S_RD) begin
      middle[c_q] <= px_q;
    end
  end

  sem_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SUM),
    .value (sq_sum),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= sem_pkg::FW_RESET;
      frame_height <= sem_pkg::FH_RESET;
      col_count    <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && !(state inside {S_EMIT_A, S_EMIT_B})) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        case (wr_index)
          sem_pkg::REG_FRAME_WIDTH: begin
            frame_width <= wr_data[sem_pkg::FW_W-1:0];
            col_count   <= '0;
            row_count   <= '0;
          end
          sem_pkg::REG_FRAME_HEIGHT: begin
            frame_height <= wr_data[sem_pkg::FH_W-1:0];
            col_count    <= '0;
            row_count    <= '0;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            c_q    <= c_eff;
            r_q    <= r_eff;
            px_q   <= pixel_in;
            int_q  <= is_int;
            bord_q <= is_bord;
            eof_q  <= is_eof;
            if ({1'b0, c_eff} + 1'b1 >= w_eff) begin
              col_count <= '0;
              row_count <= ({1'b0, r_eff} + 1'b1 >= h_eff) ? '0 : r_eff + 1'b1;
            end else begin
              col_count <= c_eff + 1'b1;
            end
            state <= S_RD;
          end
        end
        S_RD: begin
          a_q    <= a_next;
          b_q    <= b_next;
          win[0] <= win[3];
          win[1] <= win[4];
          win[2] <= win[5];
          win[3] <= top_q;
          win[4] <= mid_q;
          win[5] <= px_q;
          if (int_q) begin
            state <= S_SQ;
          end else if (bord_q) begin
            state <= S_EMIT_B;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQ: begin
          sq_a  <= a_q * a_q;
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            mag_q <= (quarter > {1'b0, sem_pkg::PIX_MAX}) ? sem_pkg::PIX_MAX
                                                          : quarter[sem_pkg::PIX_W-1:0];
            state <= S_EMIT_A;
          end
        end
        S_EMIT_A: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            pixel_out    <= mag_q;
            out_row      <= r_q - 1'b1;
            out_col      <= c_q - 1'b1;
            last_of_run  <= !bord_q;
            end_of_frame <= 1'b0;
            state        <= bord_q ? S_EMIT_B : S_IDLE;
          end
        end
        S_EMIT_B: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            pixel_out    <= px_q;
            out_row      <= r_q;
            out_col      <= c_q;
            last_of_run  <= 1'b1;
            end_of_frame <= eof_q;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/sem_isqrt.sv]
// Iterative floor square root, two result bits per step pair, one step a cycle.
module sem_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sem_pkg::SQ_IN_W-1:0]   value,
  output logic                          done,
  output logic [sem_pkg::SQ_OUT_W-1:0]  root
);
  logic                          busy;
  logic [sem_pkg::SQ_IN_W-1:0]   v;
  logic [sem_pkg::SQ_IN_W:0]     rt;
  logic [sem_pkg::SQ_IN_W-1:0]   bt;
  logic [sem_pkg::SQ_IN_W:0]     trial;
  logic [sem_pkg::SQ_IN_W:0]     rt_next;

  assign trial = rt + {1'b0, bt};

  always_comb begin
    if ({1'b0, v} >= trial) begin
      rt_next = (rt >> 1) + {1'b0, bt};
    end else begin
      rt_next = rt >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v    <= value;
        rt   <= '0;
        bt   <= {1'b1, {(sem_pkg::SQ_IN_W-1){1'b0}}};
      end else if (busy) begin
        if ({1'b0, v} >= trial) begin
          v <= v - trial[sem_pkg::SQ_IN_W-1:0];
        end
        rt <= rt_next;
        bt <= bt >> 2;
        if (bt[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
          root <= rt_next[sem_pkg::SQ_OUT_W-1:0];
        end
      end
    end
  end
endmodule

[rtl/sem_chk.sv]
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
module sem_chk (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic last_of_run,
  input logic end_of_frame
);
  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> last_of_run)
    else $error("end of frame without last of run");
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid && $past(in_stall))
    else $error("run broken before its last request");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");
endmodule

bind sobel_edge_magnitude_3x3 sem_chk u_sem_chk (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .last_of_run  (last_of_run),
  .end_of_frame (end_of_frame)
);
